// File: rtl/bmhpq_pkg.sv
`timescale 1ns / 1ps

package bmhpq_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ID_BITS    = 16;
    localparam int KEY_BITS   = 16;
    localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_BITS = ADDR_BITS + 2;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [ID_BITS-1:0]  node_id;
        logic [KEY_BITS-1:0] cost_key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_BITS-1:0]  out_node_id;
        logic [KEY_BITS-1:0] out_cost_key;
        logic [CNT_BITS-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } t_entry;

endpackage

// File: rtl/bmhpq_mem.sv
`timescale 1ns / 1ps

// Heap entry storage: one write port, one read port, registered read data.
module bmhpq_mem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [bmhpq_pkg::ADDR_BITS-1:0]   i_waddr,
    input  bmhpq_pkg::t_entry                 i_wdata,
    input  logic [bmhpq_pkg::ADDR_BITS-1:0]   i_raddr,
    output bmhpq_pkg::t_entry                 o_rdata
);

    bmhpq_pkg::t_entry r_mem [bmhpq_pkg::HEAP_DEPTH];
    bmhpq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/binary_min_heap_priority_queue.sv
// Binary min-heap priority queue of node identifiers keyed by an unsigned 12.4 cost.
// One transaction in carries push, pop-minimum or update-key; exactly one result
// transaction comes out per input, carrying status, the popped node and key (zero
// unless a pop succeeds) and the occupancy after the operation. The heap lives in
// a single-port-write, single-port-read RAM with registered read data, and one
// sequencer with a small set of key comparators walks it a level at a time, keeping
// the moving entry in a register (hole method) so each level costs one RAM write. The
// input side stalls for the whole operation; a finished result waits in the output
// register and does not block the next input. Operation time is set by the single RAM
// read port: push and pop grow with the levels moved (at most log2 of the occupancy),
// and an update first scans the entries in index order up to the matching one, then
// moves it down and then up; an update of an absent node scans every occupied entry.
// Handing the result to the output register waits while a stalled result still
// holds it, and the sequencer passes through idle before the next input is taken.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bmhpq_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bmhpq_pkg::t_out_item  o_out_data
);

    localparam int A = bmhpq_pkg::ADDR_BITS;
    localparam int C = bmhpq_pkg::CNT_BITS;
    localparam int K = bmhpq_pkg::CHILD_BITS;

    typedef enum logic [12:0] {
        S_IDLE     = 13'h0001,
        S_START    = 13'h0002,
        S_SEARCH   = 13'h0004,
        S_POP_ROOT = 13'h0008,
        S_POP_LOAD = 13'h0010,
        S_DN_LEFT  = 13'h0020,
        S_DN_RIGHT = 13'h0040,
        S_DN_CMP   = 13'h0080,
        S_UP_LOAD  = 13'h0100,
        S_UP_FETCH = 13'h0200,
        S_UP_STEP  = 13'h0400,
        S_UP_CMP   = 13'h0800,
        S_RESP     = 13'h1000
    } t_state;

    t_state                        r_state, n_state;
    logic [C-1:0]                  r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    bmhpq_pkg::t_out_item          r_out, n_out;
    bmhpq_pkg::t_in_item           r_in, n_in;
    logic [A-1:0]                  r_pos, n_pos;
    bmhpq_pkg::t_entry             r_cur, n_cur;
    bmhpq_pkg::t_entry             r_pick, n_pick;
    logic [A-1:0]                  r_upd_pos, n_upd_pos;
    logic                          r_after_up, n_after_up;
    logic [C-1:0]                  r_idx, n_idx;
    logic                          r_chk, n_chk;
    logic [A-1:0]                  r_chk_idx, n_chk_idx;
    logic [1:0]                    r_status, n_status;
    logic [bmhpq_pkg::ID_BITS-1:0] r_res_id, n_res_id;
    logic [bmhpq_pkg::KEY_BITS-1:0] r_res_key, n_res_key;

    logic                          mem_we;
    logic [A-1:0]                  mem_waddr;
    bmhpq_pkg::t_entry             mem_wdata;
    logic [A-1:0]                  mem_raddr;
    bmhpq_pkg::t_entry             mem_rdata;

    logic [K-1:0]                  left_idx, right_idx, cnt_ext;
    logic                          has_left, has_right, pick_right;
    bmhpq_pkg::t_entry             pick_ent;
    logic [A-1:0]                  pick_pos, parent_pos;
    logic [C-1:0]                  last_idx;

    bmhpq_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Child and parent indexes of the current hole.
    assign left_idx   = {1'b0, r_pos, 1'b1};
    assign right_idx  = left_idx + K'(1);
    assign cnt_ext    = K'(r_count);
    assign has_left   = left_idx < cnt_ext;
    assign has_right  = right_idx < cnt_ext;
    assign parent_pos = (r_pos - A'(1)) >> 1;
    assign last_idx   = r_count - C'(1);

    // Right child wins a tie; it is picked unless the left key is strictly smaller.
    assign pick_right = has_right && !(r_pick.key < mem_rdata.key);
    assign pick_ent   = pick_right ? mem_rdata : r_pick;
    assign pick_pos   = pick_right ? right_idx[A-1:0] : left_idx[A-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_in        = r_in;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_pick      = r_pick;
        n_upd_pos   = r_upd_pos;
        n_after_up  = r_after_up;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_status    = r_status;
        n_res_id    = r_res_id;
        n_res_key   = r_res_key;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_cur;
        mem_raddr   = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_status  = bmhpq_pkg::ST_OK;
                n_res_id  = '0;
                n_res_key = '0;
                unique case (r_in.action)
                    bmhpq_pkg::ACT_PUSH: begin
                        if (r_count >= C'(bmhpq_pkg::HEAP_DEPTH)) begin
                            n_status = bmhpq_pkg::ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_pos   = r_count[A-1:0];
                            n_count = r_count + C'(1);
                            n_cur   = '{id: r_in.node_id, key: r_in.cost_key};
                            n_state = S_UP_STEP;
                        end
                    end
                    bmhpq_pkg::ACT_POP: begin
                        if (r_count == '0) begin
                            n_status = bmhpq_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            mem_raddr = '0;
                            n_state   = S_POP_ROOT;
                        end
                    end
                    bmhpq_pkg::ACT_UPDATE: begin
                        n_idx   = '0;
                        n_chk   = 1'b0;
                        n_state = S_SEARCH;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end

            // Read one entry a cycle; check the entry read in the cycle before.
            S_SEARCH: begin
                mem_raddr = r_idx[A-1:0];
                if (r_chk && (mem_rdata.id == r_in.node_id)) begin
                    n_cur      = '{id: r_in.node_id, key: r_in.cost_key};
                    n_pos      = r_chk_idx;
                    n_upd_pos  = r_chk_idx;
                    n_after_up = 1'b1;
                    n_state    = S_DN_LEFT;
                end else if (r_idx == r_count) begin
                    n_status = bmhpq_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[A-1:0];
                    n_idx     = r_idx + C'(1);
                end
            end

            S_POP_ROOT: begin
                n_res_id  = mem_rdata.id;
                n_res_key = mem_rdata.key;
                n_count   = last_idx;
                mem_raddr = last_idx[A-1:0];
                n_state   = S_POP_LOAD;
            end

            S_POP_LOAD: begin
                n_cur      = mem_rdata;
                n_pos      = '0;
                n_after_up = 1'b0;
                n_state    = S_DN_LEFT;
            end

            S_DN_LEFT: begin
                if (has_left) begin
                    mem_raddr = left_idx[A-1:0];
                    n_state   = S_DN_RIGHT;
                end else begin
                    mem_we  = 1'b1;
                    n_state = r_after_up ? S_UP_LOAD : S_RESP;
                end
            end

            S_DN_RIGHT: begin
                n_pick    = mem_rdata;
                mem_raddr = right_idx[A-1:0];
                n_state   = S_DN_CMP;
            end

            S_DN_CMP: begin
                mem_we = 1'b1;
                if (pick_ent.key < r_cur.key) begin
                    mem_wdata = pick_ent;
                    n_pos     = pick_pos;
                    n_state   = S_DN_LEFT;
                end else begin
                    n_state = r_after_up ? S_UP_LOAD : S_RESP;
                end
            end

            S_UP_LOAD: begin
                mem_raddr = r_upd_pos;
                n_pos     = r_upd_pos;
                n_state   = S_UP_FETCH;
            end

            S_UP_FETCH: begin
                n_cur   = mem_rdata;
                n_state = S_UP_STEP;
            end

            S_UP_STEP: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    mem_raddr = parent_pos;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_cur.key < mem_rdata.key) begin
                    mem_wdata = mem_rdata;
                    n_pos     = parent_pos;
                    n_state   = S_UP_STEP;
                end else begin
                    n_state = S_RESP;
                end
            end

            // Hold until the output register is free.
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = '{status:       r_status,
                              out_node_id:  r_res_id,
                              out_cost_key: r_res_key,
                              occupancy:    r_count};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_in       <= n_in;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_pick     <= n_pick;
        r_upd_pos  <= n_upd_pos;
        r_after_up <= n_after_up;
        r_idx      <= n_idx;
        r_chk      <= n_chk;
        r_chk_idx  <= n_chk_idx;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_key  <= n_res_key;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C'(bmhpq_pkg::HEAP_DEPTH))
        else $error("heap occupancy beyond depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (C'(mem_waddr) < r_count) || (mem_waddr == '0))
        else $error("heap write outside occupied entries");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_START))
        else $error("accepted transaction did not start an operation");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == bmhpq_pkg::ST_FULL))
        |-> (o_out_data.occupancy == C'(bmhpq_pkg::HEAP_DEPTH)))
        else $error("full status with heap not full");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == bmhpq_pkg::ST_EMPTY))
        |-> (o_out_data.occupancy == '0) && (o_out_data.out_node_id == '0))
        else $error("empty status with nonzero occupancy or node");
`endif

endmodule
